/* rtl/rxlb_pkg.sv */
// Package with the shared types, constants and microcode program of the receive line buffer.
`default_nettype none
package rxlb_pkg;

	localparam int DEF_FIFO_DEPTH = 64;
	localparam int DEF_LINE_LENGTH = 64;

	localparam logic [7:0] CHAR_LF  = 8'h0A;
	localparam logic [7:0] CHAR_CR  = 8'h0D;
	localparam logic [7:0] CHAR_NUL = 8'h00;

	localparam logic [1:0] OP_RECEIVE   = 2'd0;
	localparam logic [1:0] OP_READ_BYTE = 2'd1;
	localparam logic [1:0] OP_READ_LINE = 2'd2;

	localparam logic [2:0] PC_FETCH   = 3'd0;
	localparam logic [2:0] PC_RECV    = 3'd1;
	localparam logic [2:0] PC_STATUS  = 3'd2;
	localparam logic [2:0] PC_POP     = 3'd3;
	localparam logic [2:0] PC_POP_OUT = 3'd4;
	localparam logic [2:0] PC_LCHECK  = 3'd5;
	localparam logic [2:0] PC_LSTREAM = 3'd6;

	localparam logic [2:0] ACT_NONE    = 3'd0;
	localparam logic [2:0] ACT_RECV    = 3'd1;
	localparam logic [2:0] ACT_STATUS  = 3'd2;
	localparam logic [2:0] ACT_POP     = 3'd3;
	localparam logic [2:0] ACT_POP_OUT = 3'd4;
	localparam logic [2:0] ACT_LSTART  = 3'd5;
	localparam logic [2:0] ACT_LSTREAM = 3'd6;

	localparam logic [1:0] BR_GOTO   = 2'd0;
	localparam logic [1:0] BR_START  = 2'd1;
	localparam logic [1:0] BR_NOLINE = 2'd2;
	localparam logic [1:0] BR_MORE   = 2'd3;

	typedef struct packed {
		logic [2:0] act;
		logic [1:0] br;
		logic [2:0] target;
	} ucw_t;

	function automatic ucw_t ucode_rom(input logic [2:0] pc);
		ucw_t w;
		case (pc)
			PC_FETCH:   w = '{act: ACT_NONE,    br: BR_START,  target: PC_FETCH};
			PC_RECV:    w = '{act: ACT_RECV,    br: BR_GOTO,   target: PC_STATUS};
			PC_STATUS:  w = '{act: ACT_STATUS,  br: BR_GOTO,   target: PC_FETCH};
			PC_POP:     w = '{act: ACT_POP,     br: BR_GOTO,   target: PC_POP_OUT};
			PC_POP_OUT: w = '{act: ACT_POP_OUT, br: BR_GOTO,   target: PC_FETCH};
			PC_LCHECK:  w = '{act: ACT_LSTART,  br: BR_NOLINE, target: PC_STATUS};
			PC_LSTREAM: w = '{act: ACT_LSTREAM, br: BR_MORE,   target: PC_LSTREAM};
			default:    w = '{act: ACT_NONE,    br: BR_GOTO,   target: PC_FETCH};
		endcase
		return w;
	endfunction

	function automatic logic [2:0] dispatch_rom(input logic [1:0] op);
		logic [2:0] pc;
		case (op)
			OP_RECEIVE:   pc = PC_RECV;
			OP_READ_BYTE: pc = PC_POP;
			OP_READ_LINE: pc = PC_LCHECK;
			default:      pc = PC_STATUS;
		endcase
		return pc;
	endfunction

endpackage
`default_nettype wire

/* rtl/rx_byte_fifo_with_line_assembler_top.sv */
// Top level of the receive byte FIFO with line assembler, a microcoded sequencer.
//
// A command is taken at a rising edge where start is high and busy is low.
// operation 0 delivers a received byte, 1 pops one byte from the FIFO and
// 2 reads out the pending line; any other code only reports status.
// Every command yields results on data_byte, data_valid, last, fifo_nonempty
// and line_pending, each shown for one cycle with strobe high; the receiver
// cannot stall them, and the last result of a command has last set.
// A received byte passes through the receive and status steps before its
// result, a status command goes to the status step alone, and a byte read
// passes through the pop and pop output steps. A line read checks for a
// pending line, reports only status if there is none, and else returns one
// character per cycle. The pace is set by the microcode program: one control
// word per cycle and the registered read ports of the FIFO and line memories.
// busy falls in the cycle that shows the last result, so the next command may be accepted then.
// Reset empties the FIFO and drops any partial or pending line.
`default_nettype none
module rx_byte_fifo_with_line_assembler_top
	import rxlb_pkg::*;
#(
	parameter int FIFO_DEPTH = DEF_FIFO_DEPTH,
	parameter int LINE_LENGTH = DEF_LINE_LENGTH
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	output logic            busy,
	input  wire logic [1:0] operation,
	input  wire logic [7:0] rx_byte,
	output logic            strobe,
	output logic [7:0]      data_byte,
	output logic            data_valid,
	output logic            last,
	output logic            fifo_nonempty,
	output logic            line_pending
);

	localparam int FIFO_PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int LINE_IW = (LINE_LENGTH > 1) ? $clog2(LINE_LENGTH) : 1;

	logic [2:0]         pc_q;
	logic [2:0]         pc_next;
	ucw_t               uw;
	logic [7:0]         byte_q;
	logic [FIFO_PW-1:0] wp_q;
	logic [FIFO_PW-1:0] rp_q;
	logic [FIFO_PW-1:0] wp_inc;
	logic [FIFO_PW-1:0] rp_inc;
	logic [LINE_IW-1:0] fill_q;
	logic [LINE_IW-1:0] count_q;
	logic [LINE_IW-1:0] len_q;
	logic [LINE_IW-1:0] line_raddr;
	logic               ready_q;
	logic               pop_valid_q;
	logic               more;
	logic [7:0]         fifo_mem [FIFO_DEPTH];
	logic [7:0]         line_mem [LINE_LENGTH];
	logic [7:0]         fifo_rd_q;
	logic [7:0]         line_rd_q;

	assign uw = ucode_rom(pc_q);
	assign busy = (pc_q != PC_FETCH);
	assign fifo_nonempty = (wp_q != rp_q);
	assign line_pending = ready_q;

	assign wp_inc = (wp_q == FIFO_PW'(FIFO_DEPTH - 1)) ? '0 : wp_q + 1'b1;
	assign rp_inc = (rp_q == FIFO_PW'(FIFO_DEPTH - 1)) ? '0 : rp_q + 1'b1;

	assign more = (len_q < count_q) && (len_q < LINE_IW'(LINE_LENGTH - 1))
		&& (line_rd_q != CHAR_NUL);
	assign line_raddr = (uw.act == ACT_LSTREAM && more) ? len_q + 1'b1 : '0;

	always_comb begin
		case (uw.br)
			BR_START:  pc_next = start ? dispatch_rom(operation) : PC_FETCH;
			BR_NOLINE: pc_next = ready_q ? PC_LSTREAM : uw.target;
			BR_MORE:   pc_next = more ? uw.target : PC_FETCH;
			default:   pc_next = uw.target;
		endcase
	end

	always_ff @(posedge clk) begin
		if (uw.act == ACT_RECV && wp_inc != rp_q) begin
			fifo_mem[wp_q] <= byte_q;
		end
		fifo_rd_q <= fifo_mem[rp_q];
	end

	always_ff @(posedge clk) begin
		if (uw.act == ACT_RECV && !ready_q && byte_q != CHAR_LF && byte_q != CHAR_CR
			&& fill_q < LINE_IW'(LINE_LENGTH - 1)) begin
			line_mem[fill_q] <= byte_q;
		end
		line_rd_q <= line_mem[line_raddr];
	end

	always_ff @(posedge clk) begin
		if (pc_q == PC_FETCH && start) begin
			byte_q <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_FETCH;
			wp_q <= '0;
			rp_q <= '0;
			fill_q <= '0;
			count_q <= '0;
			len_q <= '0;
			ready_q <= 1'b0;
			pop_valid_q <= 1'b0;
			strobe <= 1'b0;
			data_byte <= '0;
			data_valid <= 1'b0;
			last <= 1'b0;
		end else begin
			pc_q <= pc_next;
			strobe <= 1'b0;
			case (uw.act)
				ACT_RECV: begin
					if (wp_inc != rp_q) begin
						wp_q <= wp_inc;
					end
					if (!ready_q) begin
						if (byte_q == CHAR_LF || byte_q == CHAR_CR) begin
							count_q <= fill_q;
							ready_q <= 1'b1;
							fill_q <= '0;
						end else if (fill_q < LINE_IW'(LINE_LENGTH - 1)) begin
							fill_q <= fill_q + 1'b1;
						end else begin
							fill_q <= '0;
						end
					end
				end
				ACT_STATUS: begin
					strobe <= 1'b1;
					data_byte <= CHAR_NUL;
					data_valid <= 1'b0;
					last <= 1'b1;
				end
				ACT_POP: begin
					pop_valid_q <= (wp_q != rp_q);
					if (wp_q != rp_q) begin
						rp_q <= rp_inc;
					end
				end
				ACT_POP_OUT: begin
					strobe <= 1'b1;
					data_byte <= pop_valid_q ? fifo_rd_q : CHAR_NUL;
					data_valid <= pop_valid_q;
					last <= 1'b1;
				end
				ACT_LSTART: begin
					len_q <= '0;
					ready_q <= 1'b0;
				end
				ACT_LSTREAM: begin
					strobe <= 1'b1;
					data_valid <= 1'b1;
					if (more) begin
						data_byte <= line_rd_q;
						last <= 1'b0;
						len_q <= len_q + 1'b1;
					end else begin
						data_byte <= CHAR_NUL;
						last <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |-> !busy)
		else $error("Sequencer still busy after the last result of a transaction.");

	a_stream_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |-> data_valid && !line_pending)
		else $error("Line character streamed while a line is still pending.");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("Accepted transaction did not start the sequencer.");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !data_valid |-> data_byte == CHAR_NUL)
		else $error("Result without valid data carries a nonzero byte.");

	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= LINE_IW'(LINE_LENGTH - 1) && count_q <= LINE_IW'(LINE_LENGTH - 1))
		else $error("Line fill index or length out of range.");
`endif

endmodule
`default_nettype wire

/* verif/tb_top.sv */
// Self-checking testbench for the receive byte FIFO with line assembler.
module tb_top;
	import rxlb_pkg::*;

	localparam int FIFO_SLOTS = DEF_FIFO_DEPTH;
	localparam int LINE_SLOTS = DEF_LINE_LENGTH;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int DRAIN_CYCLES = LINE_SLOTS + 8;

	typedef struct {
		logic [7:0] data_byte;
		logic       data_valid;
		logic       last;
		logic       fifo_nonempty;
		logic       line_pending;
	} rx_result_t;

	logic       clk;
	logic       arst_n;
	logic       start;
	logic       busy;
	logic [1:0] operation;
	logic [7:0] rx_byte;
	logic       strobe;
	logic [7:0] data_byte;
	logic       data_valid;
	logic       last;
	logic       fifo_nonempty;
	logic       line_pending;

	rx_result_t awaited_results[$];
	int         fail_count = 0;
	int         items_sent = 0;
	int         idle_pct = 0;

	logic [7:0] fifo_image[FIFO_SLOTS];
	int         fifo_wr = 0;
	int         fifo_rd = 0;
	logic [7:0] line_image[LINE_SLOTS];
	int         line_fill = 0;
	int         line_len = 0;
	logic       line_ready = 1'b0;

	rx_byte_fifo_with_line_assembler_top #(
		.FIFO_DEPTH(FIFO_SLOTS),
		.LINE_LENGTH(LINE_SLOTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.operation(operation),
		.rx_byte(rx_byte),
		.strobe(strobe),
		.data_byte(data_byte),
		.data_valid(data_valid),
		.last(last),
		.fifo_nonempty(fifo_nonempty),
		.line_pending(line_pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#3000000;
		$display("TEST FAILED");
		$finish;
	end

	task automatic push_status(input logic [7:0] d, input logic v, input logic l);
		rx_result_t r;
		r.data_byte = d;
		r.data_valid = v;
		r.last = l;
		r.fifo_nonempty = (fifo_wr != fifo_rd);
		r.line_pending = line_ready;
		awaited_results.push_back(r);
	endtask

	task automatic predict_transaction(input logic [1:0] op, input logic [7:0] b);
		logic [7:0] chars[$];
		logic [7:0] d;
		logic       v;
		int         nxt;
		int         n;
		case (op)
			OP_RECEIVE: begin
				nxt = (fifo_wr + 1) % FIFO_SLOTS;
				if (nxt != fifo_rd) begin
					fifo_image[fifo_wr] = b;
					fifo_wr = nxt;
				end
				if (!line_ready) begin
					if (b == CHAR_LF || b == CHAR_CR) begin
						line_len = line_fill;
						line_ready = 1'b1;
						line_fill = 0;
					end else if (line_fill < LINE_SLOTS - 1) begin
						line_image[line_fill] = b;
						line_fill++;
					end else begin
						line_fill = 0;
					end
				end
				push_status(CHAR_NUL, 1'b0, 1'b1);
			end
			OP_READ_BYTE: begin
				d = CHAR_NUL;
				v = 1'b0;
				if (fifo_wr != fifo_rd) begin
					d = fifo_image[fifo_rd];
					v = 1'b1;
					fifo_rd = (fifo_rd + 1) % FIFO_SLOTS;
				end
				push_status(d, v, 1'b1);
			end
			OP_READ_LINE: begin
				if (!line_ready) begin
					push_status(CHAR_NUL, 1'b0, 1'b1);
				end else begin
					n = 0;
					while (n < line_len && n < LINE_SLOTS - 1 && line_image[n] != CHAR_NUL) begin
						chars.push_back(line_image[n]);
						n++;
					end
					line_ready = 1'b0;
					foreach (chars[i])
						push_status(chars[i], 1'b1, 1'b0);
					push_status(CHAR_NUL, 1'b1, 1'b1);
				end
			end
			default: begin
				push_status(CHAR_NUL, 1'b0, 1'b1);
			end
		endcase
	endtask

	// Called at a rising edge; returns at the edge that accepted the transaction.
	task automatic send_transaction(input logic [1:0] op, input logic [7:0] b);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		start <= 1'b1;
		operation <= op;
		rx_byte <= b;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		predict_transaction(op, b);
		if (op != OP_UNUSED)
			items_sent++;
	endtask

	task automatic wait_results_drained();
		start <= 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	function automatic logic [7:0] line_char();
		logic [7:0] c;
		if ($urandom_range(7) == 0)
			return CHAR_NUL;
		do
			c = 8'($urandom_range(1, 255));
		while (c == CHAR_LF || c == CHAR_CR);
		return c;
	endfunction

	always @(posedge clk) begin
		rx_result_t e;
		if (arst_n === 1'b1 && strobe === 1'b1) begin
			if (awaited_results.size() == 0) begin
				$error("Result with no transaction outstanding: data_byte %0h", data_byte);
				fail_count++;
			end else begin
				e = awaited_results.pop_front();
				if (data_byte !== e.data_byte) begin
					$error("data_byte: expected %0h, got %0h", e.data_byte, data_byte);
					fail_count++;
				end
				if (data_valid !== e.data_valid) begin
					$error("data_valid: expected %0b, got %0b", e.data_valid, data_valid);
					fail_count++;
				end
				if (last !== e.last) begin
					$error("last: expected %0b, got %0b", e.last, last);
					fail_count++;
				end
				if (fifo_nonempty !== e.fifo_nonempty) begin
					$error("fifo_nonempty: expected %0b, got %0b",
						e.fifo_nonempty, fifo_nonempty);
					fail_count++;
				end
				if (line_pending !== e.line_pending) begin
					$error("line_pending: expected %0b, got %0b",
						e.line_pending, line_pending);
					fail_count++;
				end
			end
		end
	end

	task automatic test_empty_reads();
		send_transaction(OP_READ_BYTE, 8'h00);
		send_transaction(OP_READ_LINE, 8'hFF);
		send_transaction(OP_UNUSED, 8'hFF);
		send_transaction(OP_UNUSED, 8'h00);
	endtask

	task automatic test_empty_lines();
		send_transaction(OP_RECEIVE, CHAR_CR);
		send_transaction(OP_READ_LINE, 8'h00);
		send_transaction(OP_RECEIVE, CHAR_LF);
		send_transaction(OP_READ_LINE, 8'h00);
		send_transaction(OP_READ_BYTE, 8'h00);
		send_transaction(OP_READ_BYTE, 8'h00);
	endtask

	// A NUL inside a line cuts the readout short, and bytes arriving while a
	// line is pending reach only the FIFO.
	task automatic test_nul_and_pending();
		send_transaction(OP_RECEIVE, 8'hFF);
		send_transaction(OP_RECEIVE, CHAR_NUL);
		send_transaction(OP_RECEIVE, 8'h7F);
		send_transaction(OP_RECEIVE, CHAR_LF);
		send_transaction(OP_RECEIVE, 8'h80);
		send_transaction(OP_READ_LINE, 8'h00);
		repeat (6)
			send_transaction(OP_READ_BYTE, 8'h00);
	endtask

	// Fill the FIFO to its limit, stream a line of the longest length, then
	// overflow the line so that its fill index wraps.
	task automatic test_capacity();
		repeat (LINE_SLOTS - 1)
			send_transaction(OP_RECEIVE, line_char() | 8'h20);
		send_transaction(OP_RECEIVE, CHAR_LF);
		send_transaction(OP_READ_LINE, 8'($urandom_range(255)));
		repeat (LINE_SLOTS)
			send_transaction(OP_RECEIVE, line_char());
		send_transaction(OP_RECEIVE, CHAR_CR);
		send_transaction(OP_READ_LINE, 8'($urandom_range(255)));
		repeat (FIFO_SLOTS)
			send_transaction(OP_READ_BYTE, 8'($urandom_range(255)));
	endtask

	task automatic test_random_mix(input int count);
		int base;
		int rel;
		int pick;
		base = items_sent;
		while (items_sent - base < count) begin
			rel = items_sent - base;
			idle_pct = (rel < count / 3) ? 37 : (rel < 2 * count / 3) ? 55 : 0;
			pick = $urandom_range(99);
			if (pick < 40) begin
				repeat ($urandom_range(0, 12))
					send_transaction(OP_RECEIVE, line_char());
				if ($urandom_range(99) < 85)
					send_transaction(OP_RECEIVE, $urandom_range(1) ? CHAR_LF : CHAR_CR);
			end else if (pick < 65) begin
				send_transaction(OP_READ_LINE, 8'($urandom_range(255)));
			end else if (pick < 93) begin
				send_transaction(OP_READ_BYTE, 8'($urandom_range(255)));
			end else begin
				send_transaction(2'($urandom_range(3)), 8'($urandom_range(255)));
			end
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		start <= 1'b0;
		operation <= OP_RECEIVE;
		rx_byte <= 8'h00;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_pct = 37;
		test_empty_reads();
		test_empty_lines();
		wait_results_drained();
		test_nul_and_pending();
		wait_results_drained();
		idle_pct = 55;
		test_capacity();
		wait_results_drained();
		test_random_mix(45);

		wait_results_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && awaited_results.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			if (awaited_results.size() != 0)
				$error("%0d expected results never arrived", awaited_results.size());
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
